FILE: hdl/pie_pkg.sv
// ---------------------------------------------------------------------------
// pie_pkg: shared types and constants
// Transaction structs, register indexes, window geometry and the per-cell
// compare pattern for the primer id window extractor.
// ---------------------------------------------------------------------------
package pie_pkg;

  // Window geometry
  localparam int WIN_LEN         = 31;
  localparam int ID_LEN          = 21;
  localparam int NOID_LEN        = 10;
  localparam int ID_OFFSET       = 8;
  localparam int MARKER_LEN      = 10;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int LEN_WIDTH       = 16;
  localparam int POS_WIDTH       = 5;

  localparam logic [7:0]  CHAR_N        = 8'h4E;
  localparam logic [7:0]  CHAR_A        = 8'h41;
  localparam logic [7:0]  CHAR_C        = 8'h43;
  localparam logic [7:0]  CHAR_G        = 8'h47;
  localparam logic [7:0]  CHAR_T        = 8'h54;
  localparam logic [39:0] MARKER_RESET  = 40'h4E4E4E4E4E;
  localparam logic [15:0] THRESH_RESET  = 16'd350;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MARKER_LOW  = 2'd0,
    CFG_MARKER_HIGH = 2'd1,
    CFG_THRESHOLD   = 2'd2
  } cfg_index_t;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_LONG  = 2'd1,
    VERDICT_SHORT = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] base_byte;
    logic       final_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]           id_byte;
    logic [POS_WIDTH-1:0] id_position;
    logic [1:0]           verdict;
    logic [LEN_WIDTH-1:0] sequence_length;
    logic                 run_end;
  } result_t;

  // Compare pattern of one window cell
  typedef struct packed {
    logic       en;
    logic [7:0] ch;
  } pat_t;

  // Hand-off from the window to the output run unit
  typedef struct packed {
    logic                        found;
    verdict_t                    verdict;
    logic [LEN_WIDTH-1:0]        length;
    logic [ID_LEN-1:0][7:0]      id;
  } run_load_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // Expected character of window position pos (en low: not checked)
  function automatic pat_t cell_pattern(input int pos, input logic [39:0] mlow,
                                        input logic [39:0] mhigh);
    pat_t p;
    p.en = 1'b1;
    p.ch = CHAR_N;
    if (pos < 5) begin
      p.ch = mlow[8*pos +: 8];
    end else if (pos < MARKER_LEN) begin
      p.ch = mhigh[8*(pos-5) +: 8];
    end else if (pos == 14) begin
      p.ch = CHAR_C;
    end else if (pos == 15) begin
      p.ch = CHAR_A;
    end else if (pos == 20) begin
      p.ch = CHAR_G;
    end else if (pos == 21) begin
      p.ch = CHAR_T;
    end else if (pos == 27) begin
      p.ch = CHAR_G;
    end else if (pos == 28) begin
      p.ch = CHAR_C;
    end else begin
      p.en = 1'b0;
    end
    return p;
  endfunction

endpackage

FILE: hdl/pie_cell.sv
// ---------------------------------------------------------------------------
// pie_cell: one window cell
// Holds one sequence character, takes its neighbor's character on every
// accepted transaction and checks the incoming character against its pattern.
// ---------------------------------------------------------------------------
module pie_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic [7:0]    d,
  input  pie_pkg::pat_t pat,
  output logic [7:0]    q,
  output logic          hit
);
  import pie_pkg::*;

  // Compare on the value this cell holds after the shift
  assign hit = !pat.en || (upcase(d) == pat.ch);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

FILE: hdl/pie_id_out.sv
// ---------------------------------------------------------------------------
// pie_id_out: output run unit
// Loads a finished id at sequence end and plays it out one character per
// result transaction from a shifting buffer.
// ---------------------------------------------------------------------------
module pie_id_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pie_pkg::run_load_t  load_data,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_ready,
  output pie_pkg::result_t    result
);
  import pie_pkg::*;

  localparam logic [POS_WIDTH-1:0] LAST_ID   = POS_WIDTH'(ID_LEN - 1);
  localparam logic [POS_WIDTH-1:0] LAST_NOID = POS_WIDTH'(NOID_LEN - 1);

  logic                       active;
  logic [POS_WIDTH-1:0]       pos;
  logic                       found;
  verdict_t                   verdict;
  logic [LEN_WIDTH-1:0]       length;
  logic [ID_LEN-1:0][7:0]     id_buf;
  logic [POS_WIDTH-1:0]       last_pos;
  logic                       take;

  assign last_pos = found ? LAST_ID : LAST_NOID;
  assign take     = active && result_ready;
  assign busy     = active;

  // Run control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= '0;
    end else if (load) begin
      active <= 1'b1;
      pos    <= '0;
    end else if (take) begin
      if (pos == last_pos) begin
        active <= 1'b0;
      end
      pos <= pos + 1'b1;
    end
  end

  // Payload buffer, head at entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      found   <= load_data.found;
      verdict <= load_data.verdict;
      length  <= load_data.length;
      id_buf  <= load_data.id;
    end else if (take) begin
      id_buf <= {8'h00, id_buf[ID_LEN-1:1]};
    end
  end

  // Result drive
  assign result_valid           = active;
  assign result.id_byte         = found ? id_buf[0] : CHAR_N;
  assign result.id_position     = pos;
  assign result.verdict         = verdict;
  assign result.sequence_length = length;
  assign result.run_end         = (pos == last_pos);

endmodule

FILE: hdl/primer_id_window_extractor.sv
// ---------------------------------------------------------------------------
// primer_id_window_extractor: primer id window extractor
// Streams a DNA sequence through a 31-cell window, finds the first window
// matching the marker and fixed letters, and reports the 21-character id
// (or ten N characters) with a length class at the end of each sequence.
// ---------------------------------------------------------------------------
//  channel | signals                           | direction
//  item    | item_valid, item_ready, item      | in: one character per transaction
//  result  | result_valid, result_ready, result| out: one id character per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | in: register write, always ready
//          | cfg_data                          |
//
// One character is accepted per cycle unless stalled; the window cells shift
// and compare in that same cycle. A final character starts an output run of
// 21 results (10 when no id was found), one per cycle unless stalled, from a
// buffer of its own, so the next sequence streams in meanwhile. A final
// character arriving during a run waits until the run is over. Reset (rst,
// synchronous) clears the run, match flag, count and registers to defaults.
// ---------------------------------------------------------------------------
module primer_id_window_extractor #(
  parameter int COUNT_WIDTH = pie_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  pie_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output pie_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [39:0]                  cfg_data
);
  import pie_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;

  logic [39:0]             marker_low;
  logic [39:0]             marker_high;
  logic [LEN_WIDTH-1:0]    threshold;

  logic                    match_found;
  logic [COUNT_WIDTH-1:0]  count;
  logic [COUNT_WIDTH-1:0]  count_next;
  logic [CMP_W-1:0]        count_ext;
  logic [ID_LEN-1:0][7:0]  captured_id;

  logic [WIN_LEN-1:0][7:0] win_d;
  logic [WIN_LEN-1:0][7:0] win_q;
  logic [WIN_LEN-1:0]      hits;
  pat_t [WIN_LEN-1:0]      pats;

  logic                    accept;
  logic                    capture;
  logic                    busy;
  logic                    found_now;
  run_load_t               load_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_low  <= MARKER_RESET;
      marker_high <= MARKER_RESET;
      threshold   <= THRESH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MARKER_LOW:  marker_low  <= cfg_data;
        CFG_MARKER_HIGH: marker_high <= cfg_data;
        CFG_THRESHOLD:   threshold   <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: a final character waits for the output run to drain
  assign item_ready = !(busy && item.final_byte);
  assign accept     = item_valid && item_ready;

  // Window cell chain, new character enters at the top cell
  genvar gi;
  generate
    for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
      if (gi == WIN_LEN - 1) begin : g_top
        assign win_d[gi] = item.base_byte;
      end else begin : g_mid
        assign win_d[gi] = win_q[gi+1];
      end
      assign pats[gi] = cell_pattern(gi, marker_low, marker_high);
      pie_cell u_cell (
        .clk   (clk),
        .shift (accept),
        .d     (win_d[gi]),
        .pat   (pats[gi]),
        .q     (win_q[gi]),
        .hit   (hits[gi])
      );
    end
  endgenerate

  // Saturating character count
  assign count_next = (&count) ? count : count + 1'b1;
  assign count_ext  = CMP_W'(count_next);

  assign capture   = accept && !match_found &&
                     (count_next >= COUNT_WIDTH'(WIN_LEN)) && (&hits);
  assign found_now = match_found || capture;

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      count       <= '0;
    end else if (accept) begin
      if (item.final_byte) begin
        match_found <= 1'b0;
        count       <= '0;
      end else begin
        match_found <= found_now;
        count       <= count_next;
      end
    end
  end

  // Id latch
  always_ff @(posedge clk) begin
    if (capture) begin
      captured_id <= win_d[ID_OFFSET +: ID_LEN];
    end
  end

  // End-of-sequence hand-off
  always_comb begin
    load_data.found  = found_now;
    load_data.id     = capture ? win_d[ID_OFFSET +: ID_LEN] : captured_id;
    load_data.length = (count_ext > CMP_W'({LEN_WIDTH{1'b1}})) ? {LEN_WIDTH{1'b1}}
                                                               : count_ext[LEN_WIDTH-1:0];
    if (!found_now) begin
      load_data.verdict = VERDICT_NONE;
    end else if (count_ext > CMP_W'(threshold)) begin
      load_data.verdict = VERDICT_LONG;
    end else begin
      load_data.verdict = VERDICT_SHORT;
    end
  end

  pie_id_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && item.final_byte),
    .load_data    (load_data),
    .busy         (busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A run never starts on top of one still draining
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.final_byte) |-> !busy)
    else $error("run load while output busy");

  // Final transaction always starts a run
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.final_byte) |=> result_valid)
    else $error("no run after final transaction");

  // Run end only at the last position of either run length
  a_run_end_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.run_end) |->
      (result.id_position == POS_WIDTH'(ID_LEN - 1) ||
       result.id_position == POS_WIDTH'(NOID_LEN - 1)))
    else $error("run end at wrong position");

  // A not-found run is the short one
  a_noid_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.verdict == VERDICT_NONE) |->
      (result.id_position <= POS_WIDTH'(NOID_LEN - 1)))
    else $error("not-found run too long");
`endif

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench of the primer id window extractor
// Streams DNA sequences through the block and tracks every accepted character
// in a predictor of its own. The predictor keeps the window, the id and the
// count, and queues the id characters due at each sequence end. A checker
// compares every result transaction field by field with the oldest of them.
// Directed tests cover the register extremes, case folding, the length class
// and the first match. A random part follows with planted windows, noise and
// broken windows, under random stalls on both sides.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pie_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int COUNT_MAX   = 2**COUNT_WIDTH_DEF - 1;
  localparam int LEN_MAX     = 2**LEN_WIDTH - 1;
  localparam int SETTLE      = 8;
  localparam int CA_AT       = 14;
  localparam int GT_AT       = 20;
  localparam int GC_AT       = 27;

  localparam logic [39:0] ACGT_LO = 40'h41_54_47_43_41;  // A C G T A
  localparam logic [39:0] ACGT_HI = 40'h43_41_54_47_43;  // C G T A C

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [39:0] cfg_data;

  // Predictor state
  logic [39:0] mark_lo;
  logic [39:0] mark_hi;
  logic [15:0] long_min;
  logic [7:0]  win [WIN_LEN];
  logic [7:0]  id_hold [ID_LEN];
  logic        id_seen;
  int          char_total;

  result_t     pending_id_chars[$];
  logic [7:0]  seq_buf[$];

  int          errors = 0;
  int          cycles = 0;
  bit          no_gaps = 1'b0;
  bit          sink_calm = 1'b0;
  int          stall_left = 0;

  primer_id_window_extractor #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) i_dut (
    .clk,
    .rst,
    .item_valid,
    .item_ready,
    .item,
    .result_valid,
    .result_ready,
    .result,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // Required character at a window cell; returns 0 for don't-care cells
  function automatic bit pattern_char(input int pos, output logic [7:0] ch);
    ch = 8'h00;
    if (pos < 5) begin
      ch = mark_lo[8*pos +: 8];
    end else if (pos < MARKER_LEN) begin
      ch = mark_hi[8*(pos-5) +: 8];
    end else if (pos == CA_AT || pos == GC_AT + 1) begin
      ch = CHAR_C;
    end else if (pos == CA_AT + 1) begin
      ch = CHAR_A;
    end else if (pos == GT_AT || pos == GC_AT) begin
      ch = CHAR_G;
    end else if (pos == GT_AT + 1) begin
      ch = CHAR_T;
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit window_hit();
    logic [7:0] ch;
    int         p;
    for (p = 0; p < WIN_LEN; p++) begin
      if (pattern_char(p, ch) && fold_case(win[p]) != ch) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted character
  function automatic void shift_in_char(input logic [7:0] b, input logic fin);
    result_t r;
    int      k;
    int      n;
    for (k = 0; k < WIN_LEN - 1; k++) begin
      win[k] = win[k+1];
    end
    win[WIN_LEN-1] = b;
    if (char_total < COUNT_MAX) begin
      char_total++;
    end
    if (!id_seen && char_total >= WIN_LEN && window_hit()) begin
      for (k = 0; k < ID_LEN; k++) begin
        id_hold[k] = win[ID_OFFSET+k];
      end
      id_seen = 1'b1;
    end
    if (fin) begin
      n = id_seen ? ID_LEN : NOID_LEN;
      for (k = 0; k < n; k++) begin
        r.id_byte         = id_seen ? id_hold[k] : CHAR_N;
        r.id_position     = POS_WIDTH'(k);
        r.verdict         = !id_seen ? VERDICT_NONE :
                            (char_total > long_min) ? VERDICT_LONG : VERDICT_SHORT;
        r.sequence_length = LEN_WIDTH'((char_total > LEN_MAX) ? LEN_MAX : char_total);
        r.run_end         = (k == n - 1);
        pending_id_chars.insert(pending_id_chars.size(), r);
      end
      id_seen    = 1'b0;
      char_total = 0;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_ids
    result_t want;
    if (rst === 1'b0 && result_valid === 1'b1 && result_ready) begin
      if (pending_id_chars.size() == 0) begin
        $display("%0t: unexpected result, expected none, got byte %0h pos %0d", $time,
                 result.id_byte, result.id_position);
        errors++;
      end else begin
        want = pending_id_chars.pop_front();
        compare_field("id_byte", 32'(want.id_byte), 32'(result.id_byte));
        compare_field("id_position", 32'(want.id_position), 32'(result.id_position));
        compare_field("verdict", 32'(want.verdict), 32'(result.verdict));
        compare_field("sequence_length", 32'(want.sequence_length),
                      32'(result.sequence_length));
        compare_field("run_end", 32'(want.run_end), 32'(result.run_end));
      end
    end
  end

  // Ready with random stalls, mostly short; calm stretches have none
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      sink_calm = !sink_calm;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 29) : $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL primer_id_window_extractor");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  // One character transaction; valid stays high into the next call
  task automatic send_char(input logic [7:0] b, input logic fin);
    item_t it;
    int    gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.base_byte  = b;
    it.final_byte = fin;
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    shift_in_char(b, fin);
  endtask

  task automatic play_seq();
    int k;
    for (k = 0; k < seq_buf.size(); k++) begin
      send_char(seq_buf[k], k == seq_buf.size() - 1);
    end
    seq_buf.delete();
  endtask

  // Sender pauses until every id character has come, then lets the block settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_id_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [39:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MARKER_LOW:  mark_lo  = val;
      CFG_MARKER_HIGH: mark_hi  = val;
      CFG_THRESHOLD:   long_min = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [39:0] lo, input logic [39:0] hi,
                            input logic [15:0] thr);
    wait_idle();
    put_reg(CFG_MARKER_LOW, lo);
    put_reg(CFG_MARKER_HIGH, hi);
    put_reg(CFG_THRESHOLD, {24'h0, thr});
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence builders
  // ---------------------------------------------------------------------
  // Append one character to the sequence under construction
  function automatic void queue_char(input logic [7:0] b);
    seq_buf.insert(seq_buf.size(), b);
  endfunction

  task automatic add_noise(input int n);
    repeat (n) queue_char(8'($urandom_range(0, 255)));
  endtask

  // Window matching the current marker; case_mode 0 as is, 1 mixed, 2 lower.
  // A cell given by broken gets a wrong character.
  task automatic add_window(input int case_mode, input int broken);
    logic [7:0] ch;
    int         p;
    for (p = 0; p < WIN_LEN; p++) begin
      if (pattern_char(p, ch)) begin
        if (p == broken) begin
          ch = ch ^ 8'h01;
        end else if (ch >= "A" && ch <= "Z" &&
                     (case_mode == 2 || (case_mode == 1 && $urandom_range(0, 1)))) begin
          ch = ch + 8'd32;
        end
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      queue_char(ch);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset marker is ten N characters, threshold 350
  task automatic test_defaults();
    // lone final character: no id, length 1
    queue_char("A");
    play_seq();
    // matching window one character short: window never tested
    add_window(0, -1);
    void'(seq_buf.pop_back());
    play_seq();
    // all lower-case window still matches after folding
    add_window(2, -1);
    play_seq();
    add_noise(3);
    add_window(0, -1);
    add_noise(2);
    play_seq();
  endtask

  task automatic test_marker_regs();
    // bytes zero, 128 and up in the marker and the id
    set_config(40'hFF_80_54_00_47, 40'hE1_7F_41_43_4E, 16'd350);
    add_window(1, -1);
    play_seq();
    add_window(1, 3);
    play_seq();
    // lower-case marker characters never match
    set_config(ACGT_LO, 40'h4E_74_67_63_61, 16'd350);
    add_window(0, -1);
    play_seq();
    // register extremes
    set_config(40'h0, 40'h0, 16'd350);
    add_window(0, -1);
    play_seq();
    set_config({40{1'b1}}, {40{1'b1}}, 16'd350);
    add_window(1, -1);
    add_noise(1);
    play_seq();
  endtask

  task automatic test_threshold();
    set_config(ACGT_LO, ACGT_HI, 16'd0);
    add_window(1, -1);
    play_seq();
    add_noise(5);
    play_seq();
    // length equal to threshold is short, one above is long
    set_config(ACGT_LO, ACGT_HI, 16'd31);
    add_window(1, -1);
    play_seq();
    set_config(ACGT_LO, ACGT_HI, 16'd30);
    add_window(1, -1);
    play_seq();
    set_config(ACGT_LO, ACGT_HI, 16'hFFFF);
    add_window(1, -1);
    play_seq();
  endtask

  // Only the first matching window latches the id
  task automatic test_first_match();
    set_config(ACGT_LO, ACGT_HI, 16'd40);
    add_window(0, -1);
    add_noise(4);
    add_window(1, -1);
    play_seq();
    add_window(0, 5);
    add_window(2, -1);
    play_seq();
  endtask

  task automatic test_random();
    logic [39:0] lo;
    logic [39:0] hi;
    logic [15:0] thr;
    int          sent;
    int          runs;
    int          kind;
    int          k;
    int          bad;
    sent = 0;
    runs = 0;
    while (sent < 150) begin
      // fresh marker and threshold every few sequences
      if (runs % 3 == 0) begin
        for (k = 0; k < 10; k++) begin
          case ($urandom_range(0, 7))
            0:       lo[8*(k%5) +: 8] = 8'($urandom_range(0, 255));
            1:       lo[8*(k%5) +: 8] = "A";
            2:       lo[8*(k%5) +: 8] = "C";
            3:       lo[8*(k%5) +: 8] = "G";
            4:       lo[8*(k%5) +: 8] = "T";
            default: lo[8*(k%5) +: 8] = "N";
          endcase
          if (k == 4) begin
            hi = lo;
          end
        end
        case ($urandom_range(0, 3))
          0:       thr = 16'd0;
          1:       thr = 16'hFFFF;
          default: thr = 16'($urandom_range(25, 60));
        endcase
        set_config(lo, hi, thr);
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        add_noise($urandom_range(0, 8));
        add_window($urandom_range(0, 2), -1);
        if ($urandom_range(0, 3) == 0) begin
          add_window(1, -1);
        end
        add_noise($urandom_range(0, 6));
      end else if (kind < 8) begin
        add_noise($urandom_range(1, 12));
      end else begin
        // one required cell wrong: marker or one of the fixed letter pairs
        bad = $urandom_range(0, 15);
        if (bad >= MARKER_LEN) begin
          case (bad)
            10:      bad = CA_AT;
            11:      bad = CA_AT + 1;
            12:      bad = GT_AT;
            13:      bad = GT_AT + 1;
            14:      bad = GC_AT;
            default: bad = GC_AT + 1;
          endcase
        end
        add_noise($urandom_range(0, 4));
        add_window(1, bad);
        add_noise($urandom_range(0, 3));
      end
      sent += seq_buf.size();
      runs++;
      play_seq();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_MARKER_LOW;
    cfg_data   <= '0;
    mark_lo    = MARKER_RESET;
    mark_hi    = MARKER_RESET;
    long_min   = THRESH_RESET;
    for (int k = 0; k < WIN_LEN; k++) begin
      win[k] = 8'h00;
    end
    id_seen    = 1'b0;
    char_total = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    test_marker_regs();
    test_threshold();
    test_first_match();
    test_random();

    wait_idle();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("PASS primer_id_window_extractor");
    end else begin
      $display("FAIL primer_id_window_extractor");
    end
    $finish;
  end

endmodule
